@@ hw/rtl/deq_pkg.sv @@
// ---------------------------------------------------------------------------
// Double-ended queue package
// Shared sizes, command and status codes, cell and chain control types, and controller states.
// ---------------------------------------------------------------------------
package deq_pkg;

  // Queue capacity and widths that follow from it
  localparam int DEPTH  = 16;
  localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int DATA_W = 32;
  localparam int CMD_W  = 3;
  localparam int STAT_W = 2;

  // Commands carried in the input tuser
  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_LIST       = 3'd4
  } cmd_t;

  // Result status carried in the output tuser
  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Source of the next value of one cell
  typedef enum logic [2:0] {
    SEL_HOLD,
    SEL_LEFT,
    SEL_RIGHT,
    SEL_PUSH,
    SEL_HEAD
  } cell_sel_t;

  // Movement of the chain cells for one operation
  typedef enum logic [2:0] {
    OP_NONE,
    OP_PUSH_FRONT,
    OP_PUSH_BACK,
    OP_POP_FRONT,
    OP_ROTATE
  } chain_op_t;

  // Controller states
  typedef enum logic {
    S_IDLE,
    S_LIST
  } state_t;

endpackage

@@ hw/rtl/deq_cell.sv @@
// ---------------------------------------------------------------------------
// Double-ended queue storage cell
// One word of the chain; loads from a neighbor, the push word or the head.
// ---------------------------------------------------------------------------
module deq_cell (
  input  logic                      clk,
  input  deq_pkg::cell_sel_t        sel,
  input  logic [deq_pkg::DATA_W-1:0] left_data,
  input  logic [deq_pkg::DATA_W-1:0] right_data,
  input  logic [deq_pkg::DATA_W-1:0] push_data,
  input  logic [deq_pkg::DATA_W-1:0] head_data,
  output logic [deq_pkg::DATA_W-1:0] q
);
  import deq_pkg::*;

  logic [DATA_W-1:0] q_next;

  // Pick the incoming word
  always_comb begin
    unique case (sel)
      SEL_LEFT:  q_next = left_data;
      SEL_RIGHT: q_next = right_data;
      SEL_PUSH:  q_next = push_data;
      SEL_HEAD:  q_next = head_data;
      default:   q_next = q;
    endcase
  end

  // Hold the word
  always_ff @(posedge clk) begin
    q <= q_next;
  end

endmodule

@@ hw/rtl/double_ended_queue_unit.sv @@
// ---------------------------------------------------------------------------
// Double-ended queue unit
// Bounded deque of 32-bit words kept in a chain of cells, front in cell 0.
// ---------------------------------------------------------------------------
//  channel | dir | tdata            | tuser           | tlast
//  s_*     | in  | value [31:0]     | cmd [2:0]       | -
//  m_*     | out | data [31:0]      | status [1:0]    | last
//
//  Push and pop: results go to a one-word output register; a command is taken when it is empty or being read.
//  List: one result per cycle from cell 0 while the occupied cells rotate and the output
//  is not stalled; no input is taken meanwhile.
//  Reset clears the occupancy and the controller; cell contents are not cleared.
//  A stalled output holds its word and stops the input side and the list walk.
// ---------------------------------------------------------------------------
module double_ended_queue_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [deq_pkg::DATA_W-1:0]  s_tdata,   // [31:0] value
  input  logic [deq_pkg::CMD_W-1:0]   s_tuser,   // [2:0] cmd
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [deq_pkg::DATA_W-1:0]  m_tdata,   // [31:0] data
  output logic [deq_pkg::STAT_W-1:0]  m_tuser,   // [1:0] status
  output logic                        m_tlast    // last
);
  import deq_pkg::*;

  state_t            state, state_next;
  logic [CNT_W-1:0]  occ, occ_next;
  logic [IDX_W-1:0]  cnt, cnt_next;
  logic              accept;
  logic              out_free;
  logic              list_emit;
  logic              list_start;
  logic              list_done;
  logic              out_load;
  logic [DATA_W-1:0] out_data;
  status_t           out_status;
  logic              out_last;
  chain_op_t         op;
  logic [IDX_W-1:0]  back_idx;
  logic [DATA_W-1:0] cell_q [DEPTH];
  cell_sel_t         cell_sel [DEPTH];

  assign out_free = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;
  assign back_idx = IDX_W'(occ - CNT_W'(1));

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (list_start) state_next = S_LIST;
      S_LIST:  if (list_done) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Controller outputs
  always_comb begin
    s_tready  = 1'b0;
    list_emit = 1'b0;
    unique case (state)
      S_IDLE:  s_tready = out_free;
      S_LIST:  list_emit = out_free;
      default: ;
    endcase
  end

  // Decode the command and build the result
  always_comb begin
    out_load   = 1'b0;
    out_data   = '0;
    out_status = ST_OK;
    out_last   = 1'b1;
    occ_next   = occ;
    cnt_next   = cnt;
    op         = OP_NONE;
    list_start = 1'b0;
    list_done  = 1'b0;
    if (accept) begin
      unique case (s_tuser)
        CMD_PUSH_FRONT: begin
          out_load = 1'b1;
          if (occ == CNT_W'(DEPTH)) begin
            out_status = ST_FULL;
          end else begin
            op       = OP_PUSH_FRONT;
            occ_next = occ + CNT_W'(1);
          end
        end
        CMD_PUSH_BACK: begin
          out_load = 1'b1;
          if (occ == CNT_W'(DEPTH)) begin
            out_status = ST_FULL;
          end else begin
            op       = OP_PUSH_BACK;
            occ_next = occ + CNT_W'(1);
          end
        end
        CMD_POP_FRONT: begin
          out_load = 1'b1;
          if (occ == '0) begin
            out_status = ST_EMPTY;
          end else begin
            out_data = cell_q[0];
            op       = OP_POP_FRONT;
            occ_next = occ - CNT_W'(1);
          end
        end
        CMD_POP_BACK: begin
          out_load = 1'b1;
          if (occ == '0) begin
            out_status = ST_EMPTY;
          end else begin
            out_data = cell_q[back_idx];
            occ_next = occ - CNT_W'(1);
          end
        end
        CMD_LIST: begin
          if (occ == '0) begin
            out_load   = 1'b1;
            out_status = ST_EMPTY;
          end else begin
            list_start = 1'b1;
            cnt_next   = '0;
          end
        end
        default: ;
      endcase
    end else if (list_emit) begin
      // Emit the head, rotate it to the back
      out_load  = 1'b1;
      out_data  = cell_q[0];
      out_last  = (cnt == back_idx);
      op        = OP_ROTATE;
      cnt_next  = cnt + IDX_W'(1);
      list_done = (cnt == back_idx);
    end
  end

  // Per-cell load select
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      cell_sel[i] = SEL_HOLD;
      case (op)
        OP_PUSH_FRONT: cell_sel[i] = (i == 0) ? SEL_PUSH : SEL_LEFT;
        OP_PUSH_BACK:  if (CNT_W'(i) == occ) cell_sel[i] = SEL_PUSH;
        OP_POP_FRONT:  if (i < DEPTH - 1) cell_sel[i] = SEL_RIGHT;
        OP_ROTATE: begin
          if (CNT_W'(i + 1) == occ) begin
            cell_sel[i] = SEL_HEAD;
          end else if (CNT_W'(i + 1) < occ) begin
            cell_sel[i] = SEL_RIGHT;
          end
        end
        default: ;
      endcase
    end
  end

  // Chain of storage cells
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [DATA_W-1:0] left_d;
    logic [DATA_W-1:0] right_d;
    if (g == 0) begin : g_first
      assign left_d = '0;
    end else begin : g_inner_l
      assign left_d = cell_q[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign right_d = '0;
    end else begin : g_inner_r
      assign right_d = cell_q[g+1];
    end
    deq_cell u_cell (
      .clk        (clk),
      .sel        (cell_sel[g]),
      .left_data  (left_d),
      .right_data (right_d),
      .push_data  (s_tdata),
      .head_data  (cell_q[0]),
      .q          (cell_q[g])
    );
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      occ   <= '0;
      cnt   <= '0;
    end else begin
      state <= state_next;
      occ   <= occ_next;
      cnt   <= cnt_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= out_data;
      m_tuser <= out_status;
      m_tlast <= out_last;
    end
  end

endmodule

@@ hw/rtl/deq_checker.sv @@
// ---------------------------------------------------------------------------
// Double-ended queue port checker
// Watches the top-level ports for result coding, input stalling and output stability.
// ---------------------------------------------------------------------------
module deq_port_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        s_tready,
  input logic                        m_tvalid,
  input logic                        m_tready,
  input logic [deq_pkg::DATA_W-1:0]  m_tdata,
  input logic [deq_pkg::STAT_W-1:0]  m_tuser,
  input logic                        m_tlast
);
  import deq_pkg::*;

  // Only the three defined status codes appear
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser == ST_OK || m_tuser == ST_EMPTY || m_tuser == ST_FULL))
    else $error("undefined status code on output");

  // Empty and full results carry zero data and close the item
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser != ST_OK) |-> (m_tdata == '0 && m_tlast))
    else $error("error result with data or without last");

  // Only list words can be non-last, and those are always ok
  a_mid_ok: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tlast) |-> (m_tuser == ST_OK))
    else $error("non-last result with error status");

  // No new input is taken while a stalled result is pending
  a_no_take_stalled: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |-> !s_tready)
    else $error("input taken while output stalled");

  // A stalled word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                 && $stable(m_tlast)))
    else $error("stalled output changed");

endmodule

bind double_ended_queue_unit deq_port_checker u_deq_checker (.*);
